// ===== hw/rtl/ted_pkg.sv =====
package ted_pkg;

	localparam int RAW_BITS_DEF   = 32;
	localparam int SCREEN_DIM_MAX = 4096;
	localparam int DIM_W          = 13;
	localparam int PT_W           = 12;
	localparam int QUEUE_DEPTH    = 2;
	localparam int CFG_AW         = 5;

	// largest usable screen dimension, limited by SCREEN_DIM_MAX and by the register width
	localparam int DIM_CAP = (SCREEN_DIM_MAX < (2 ** DIM_W) - 1) ? SCREEN_DIM_MAX
	                                                              : (2 ** DIM_W) - 1;
	localparam logic [DIM_W-1:0] DIM_CAP_V = DIM_W'(DIM_CAP);

	localparam logic [4:0] EV_SYN = 5'd0;
	localparam logic [4:0] EV_KEY = 5'd1;
	localparam logic [4:0] EV_ABS = 5'd3;

	localparam logic [9:0] CODE_SYNC_FRAME  = 10'd0;
	localparam logic [9:0] ABS_X            = 10'd0;
	localparam logic [9:0] ABS_Y            = 10'd1;
	localparam logic [9:0] CODE_MT_SLOT     = 10'd47;
	localparam logic [9:0] CODE_MT_POS_X    = 10'd53;
	localparam logic [9:0] CODE_MT_POS_Y    = 10'd54;
	localparam logic [9:0] CODE_MT_TRACK_ID = 10'd57;
	localparam logic [9:0] CODE_TOUCH_BTN   = 10'd330;

	localparam logic [1:0] KIND_DOWN = 2'd0;
	localparam logic [1:0] KIND_MOVE = 2'd1;
	localparam logic [1:0] KIND_UP   = 2'd2;

	localparam logic [2:0] REG_X_MIN  = 3'd0;
	localparam logic [2:0] REG_X_MAX  = 3'd1;
	localparam logic [2:0] REG_Y_MIN  = 3'd2;
	localparam logic [2:0] REG_Y_MAX  = 3'd3;
	localparam logic [2:0] REG_WIDTH  = 3'd4;
	localparam logic [2:0] REG_HEIGHT = 3'd5;
	localparam logic [2:0] REG_ORIENT = 3'd6;

	typedef struct packed {
		logic [4:0]         req_type;
		logic [9:0]         event_code;
		logic signed [31:0] event_value;
	} evt_word_t;

	typedef struct packed {
		logic [1:0]      touch_kind;
		logic [PT_W-1:0] screen_x;
		logic [PT_W-1:0] screen_y;
	} touch_word_t;

	typedef struct packed {
		logic [DIM_W-1:0] screen_width;
		logic [DIM_W-1:0] screen_height;
		logic [2:0]       orientation;
	} view_cfg_t;

	// screen dimension after clamping, minus one; zero stays zero
	function automatic logic [DIM_W-1:0] dim_max(input logic [DIM_W-1:0] d);
		logic [DIM_W-1:0] r;
		if (d == '0) begin
			r = '0;
		end else if (d > DIM_CAP_V) begin
			r = DIM_CAP_V - DIM_W'(1);
		end else begin
			r = d - DIM_W'(1);
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/ted_front.sv =====
module ted_front import ted_pkg::*; #(
	parameter int RAW_BITS = RAW_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    evt_valid,
	output logic                    evt_stall,
	input  evt_word_t               evt,
	input  logic                    q_full,
	output logic                    q_push,
	output logic [2*RAW_BITS:0]     q_wdata
);

	logic                       slot0_q;
	logic                       active_q;
	logic                       button_q;
	logic signed [RAW_BITS-1:0] cx_q, cy_q, ux_q, uy_q;

	logic                       acc;
	logic signed [RAW_BITS-1:0] raw;
	logic                       pressed;
	logic signed [RAW_BITS-1:0] px, py;

	assign evt_stall = q_full;
	assign acc       = evt_valid && !q_full;
	assign raw       = evt.event_value[RAW_BITS-1:0];

	assign q_push = acc && (evt.req_type == EV_SYN) && (evt.event_code == CODE_SYNC_FRAME);

	// multitouch contact wins over the single-touch point
	always_comb begin
		pressed = 1'b0;
		px      = '0;
		py      = '0;
		if (active_q) begin
			pressed = 1'b1;
			px      = cx_q;
			py      = cy_q;
		end else if (button_q) begin
			pressed = 1'b1;
			px      = ux_q;
			py      = uy_q;
		end
	end

	assign q_wdata = {pressed, px, py};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot0_q  <= 1'b1;
			active_q <= 1'b0;
			button_q <= 1'b0;
			cx_q     <= '0;
			cy_q     <= '0;
			ux_q     <= '0;
			uy_q     <= '0;
		end else if (acc) begin
			if (evt.req_type == EV_ABS) begin
				case (evt.event_code)
					CODE_MT_SLOT: begin
						slot0_q <= (evt.event_value == '0);
					end
					CODE_MT_TRACK_ID: begin
						if (slot0_q) active_q <= !evt.event_value[31];
					end
					CODE_MT_POS_X: begin
						if (slot0_q) cx_q <= raw;
					end
					CODE_MT_POS_Y: begin
						if (slot0_q) cy_q <= raw;
					end
					ABS_X: begin
						ux_q <= raw;
					end
					ABS_Y: begin
						uy_q <= raw;
					end
					default: ;
				endcase
			end else if (evt.req_type == EV_KEY && evt.event_code == CODE_TOUCH_BTN) begin
				button_q <= (evt.event_value != '0);
			end
		end
	end

endmodule

// ===== hw/rtl/ted_queue.sv =====
module ted_queue import ted_pkg::*; #(
	parameter int W     = 2 * RAW_BITS_DEF + 1,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         nempty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full   = (count_q == CNT_W'(DEPTH));
	assign nempty = (count_q != '0);
	assign rdata  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("report queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> nempty)
		else $error("report queue read while empty");

endmodule

// ===== hw/rtl/ted_back.sv =====
module ted_back import ted_pkg::*; #(
	parameter int RAW_BITS = RAW_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_nempty,
	input  logic [2*RAW_BITS:0]        q_rdata,
	output logic                       q_pop,
	input  logic signed [RAW_BITS-1:0] x_min,
	input  logic signed [RAW_BITS-1:0] x_max,
	input  logic signed [RAW_BITS-1:0] y_min,
	input  logic signed [RAW_BITS-1:0] y_max,
	input  view_cfg_t                  view,
	output logic                       rpt_valid,
	input  logic                       rpt_stall,
	output touch_word_t                rpt
);

	localparam int SPAN_W = RAW_BITS + 1;
	localparam int PROD_W = RAW_BITS + DIM_W + 2;
	localparam int REM_W  = PROD_W - 1;
	localparam int QB     = DIM_W;
	localparam int CNT_W  = $clog2(QB);

	typedef enum logic [2:0] {
		S_IDLE, S_MUL, S_ADD, S_CHK, S_DIV, S_AXIS, S_EMIT
	} state_t;

	state_t                     state_q;
	logic                       pressed_q;
	logic signed [RAW_BITS-1:0] rx_q, ry_q;
	logic                       axis_q;
	logic signed [PROD_W-1:0]   prod_q, num_q;
	logic signed [SPAN_W-1:0]   span_q;
	logic [DIM_W-1:0]           omax_q, res_q;
	logic [REM_W-1:0]           rem_q, dsr_q;
	logic [QB-1:0]              quo_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [PT_W-1:0]            sx_q, sy_q, last_x_q, last_y_q;
	logic                       was_down_q;
	logic                       rpt_valid_q;
	touch_word_t                rpt_q;

	logic                       use_y;
	logic signed [RAW_BITS-1:0] v_w, lo_w, hi_w;
	logic signed [SPAN_W-1:0]   diff_w, span_w;
	logic signed [PROD_W-1:0]   prod_w;
	logic [DIM_W-1:0]           omax_w;
	logic                       span_pos;
	logic [REM_W-1:0]           span_ext, num_u;
	logic                       ge;
	logic [QB-1:0]              quo_nx;
	logic                       inv;
	logic [DIM_W-1:0]           r_adj;
	logic                       out_free;
	logic                       emit;
	logic [1:0]                 emit_kind;

	// operand selection: swap exchanges which raw axis feeds which screen axis
	assign use_y  = axis_q ^ view.orientation[0];
	assign v_w    = use_y ? ry_q  : rx_q;
	assign lo_w   = use_y ? y_min : x_min;
	assign hi_w   = use_y ? y_max : x_max;
	assign omax_w = axis_q ? dim_max(view.screen_height) : dim_max(view.screen_width);
	assign diff_w = {v_w[RAW_BITS-1], v_w} - {lo_w[RAW_BITS-1], lo_w};
	assign span_w = {hi_w[RAW_BITS-1], hi_w} - {lo_w[RAW_BITS-1], lo_w};
	assign prod_w = PROD_W'(diff_w) * PROD_W'($signed({1'b0, omax_w}));

	assign span_pos = !span_q[SPAN_W-1] && (span_q != '0);
	assign span_ext = REM_W'($unsigned(span_q));
	assign num_u    = num_q[REM_W-1:0];
	assign ge       = (rem_q >= dsr_q);
	assign quo_nx   = {quo_q[QB-2:0], ge};

	assign inv   = axis_q ? view.orientation[2] : view.orientation[1];
	assign r_adj = inv ? (omax_q - res_q) : res_q;

	assign out_free = !rpt_valid_q || !rpt_stall;

	always_comb begin
		emit      = 1'b0;
		emit_kind = KIND_DOWN;
		if (pressed_q && !was_down_q) begin
			emit = 1'b1;
		end else if (pressed_q && (sx_q != last_x_q || sy_q != last_y_q)) begin
			emit      = 1'b1;
			emit_kind = KIND_MOVE;
		end else if (!pressed_q && was_down_q) begin
			emit      = 1'b1;
			emit_kind = KIND_UP;
		end
	end

	assign q_pop     = (state_q == S_IDLE) && q_nempty;
	assign rpt_valid = rpt_valid_q;
	assign rpt       = rpt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pressed_q   <= 1'b0;
			rx_q        <= '0;
			ry_q        <= '0;
			axis_q      <= 1'b0;
			prod_q      <= '0;
			num_q       <= '0;
			span_q      <= '0;
			omax_q      <= '0;
			res_q       <= '0;
			rem_q       <= '0;
			dsr_q       <= '0;
			quo_q       <= '0;
			cnt_q       <= '0;
			sx_q        <= '0;
			sy_q        <= '0;
			last_x_q    <= '0;
			last_y_q    <= '0;
			was_down_q  <= 1'b0;
			rpt_valid_q <= 1'b0;
			rpt_q       <= '0;
		end else begin
			if (rpt_valid_q && !rpt_stall && state_q != S_EMIT) rpt_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (q_nempty) begin
						pressed_q <= q_rdata[2*RAW_BITS];
						rx_q      <= q_rdata[2*RAW_BITS-1:RAW_BITS];
						ry_q      <= q_rdata[RAW_BITS-1:0];
						axis_q    <= 1'b0;
						state_q   <= q_rdata[2*RAW_BITS] ? S_MUL : S_EMIT;
					end
				end
				S_MUL: begin
					prod_q  <= prod_w;
					span_q  <= span_w;
					omax_q  <= omax_w;
					state_q <= S_ADD;
				end
				S_ADD: begin
					// rounding term: half the span
					num_q   <= prod_q + PROD_W'(span_q >>> 1);
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (!span_pos || num_q[PROD_W-1]) begin
						res_q   <= '0;
						state_q <= S_AXIS;
					end else if (num_u >= (span_ext << QB)) begin
						// quotient would exceed any screen coordinate
						res_q   <= omax_q;
						state_q <= S_AXIS;
					end else begin
						rem_q   <= num_u;
						dsr_q   <= span_ext << (QB - 1);
						quo_q   <= '0;
						cnt_q   <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (ge) rem_q <= rem_q - dsr_q;
					dsr_q <= dsr_q >> 1;
					quo_q <= quo_nx;
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(QB - 1)) begin
						res_q   <= (quo_nx > omax_q) ? omax_q : quo_nx;
						state_q <= S_AXIS;
					end
				end
				S_AXIS: begin
					if (!axis_q) begin
						sx_q    <= r_adj[PT_W-1:0];
						axis_q  <= 1'b1;
						state_q <= S_MUL;
					end else begin
						sy_q    <= r_adj[PT_W-1:0];
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						rpt_valid_q <= emit;
						if (emit) begin
							rpt_q.touch_kind <= emit_kind;
							rpt_q.screen_x   <= (emit_kind == KIND_UP) ? last_x_q : sx_q;
							rpt_q.screen_y   <= (emit_kind == KIND_UP) ? last_y_q : sy_q;
						end
						if (pressed_q) begin
							last_x_q <= sx_q;
							last_y_q <= sy_q;
						end
						was_down_q <= pressed_q;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (rem_q < {dsr_q, 1'b0}))
		else $error("partial remainder out of range in divider");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		rpt_valid_q |-> (rpt_q.touch_kind == KIND_DOWN || rpt_q.touch_kind == KIND_MOVE
		                 || rpt_q.touch_kind == KIND_UP))
		else $error("illegal touch kind on output");

	a_kind_tracks_down: assert property (@(posedge clk) disable iff (!arst_n)
		rpt_valid_q |-> (was_down_q == (rpt_q.touch_kind != KIND_UP)))
		else $error("pending word disagrees with touch state");

endmodule

// ===== hw/rtl/touch_event_decoder_unit.sv =====
// channel   dir  handshake                 word
// evt       in   evt_valid / evt_stall     evt_word_t   (req_type, event_code, event_value)
// rpt       out  rpt_valid / rpt_stall     touch_word_t (touch_kind, screen_x, screen_y)
// apb       in   psel, penable, pwrite     paddr, pwdata, prdata; pready tied high
//
// axis, key and ignored events are taken at one per cycle while the report queue has room.
// a sync report needing no mapping goes through queue pop and output load only; with an active
// touch the mapper runs per axis multiply, add, range check, 13-step restoring divide and store,
// between queue pop and output load; an axis settled by the range check skips its divide.
// the queue holds two sync reports, so events keep flowing while the mapper is busy.
// reset clears control and state registers at once; a stalled output word holds and the
// mapper finishes the next report and waits for the slot.
module touch_event_decoder_unit import ted_pkg::*; #(
	parameter int RAW_BITS = RAW_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              evt_valid,
	output logic              evt_stall,
	input  evt_word_t         evt,
	output logic              rpt_valid,
	input  logic              rpt_stall,
	output touch_word_t       rpt,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int QW = 2 * RAW_BITS + 1;

	logic signed [RAW_BITS-1:0] x_min_q, x_max_q, y_min_q, y_max_q;
	view_cfg_t                  view_q;
	logic [2:0]                 reg_idx;
	logic                       wr_en;

	logic          q_push, q_pop, q_full, q_nempty;
	logic [QW-1:0] q_wdata, q_rdata;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_min_q             <= '0;
			x_max_q             <= '0;
			y_min_q             <= '0;
			y_max_q             <= '0;
			view_q.screen_width  <= DIM_W'(1024);
			view_q.screen_height <= DIM_W'(1024);
			view_q.orientation   <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_X_MIN:  x_min_q              <= pwdata[RAW_BITS-1:0];
				REG_X_MAX:  x_max_q              <= pwdata[RAW_BITS-1:0];
				REG_Y_MIN:  y_min_q              <= pwdata[RAW_BITS-1:0];
				REG_Y_MAX:  y_max_q              <= pwdata[RAW_BITS-1:0];
				REG_WIDTH:  view_q.screen_width  <= pwdata[DIM_W-1:0];
				REG_HEIGHT: view_q.screen_height <= pwdata[DIM_W-1:0];
				REG_ORIENT: view_q.orientation   <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_X_MIN:  prdata = 32'(x_min_q);
			REG_X_MAX:  prdata = 32'(x_max_q);
			REG_Y_MIN:  prdata = 32'(y_min_q);
			REG_Y_MAX:  prdata = 32'(y_max_q);
			REG_WIDTH:  prdata = 32'(view_q.screen_width);
			REG_HEIGHT: prdata = 32'(view_q.screen_height);
			REG_ORIENT: prdata = 32'(view_q.orientation);
			default:    prdata = '0;
		endcase
	end

	ted_front #(
		.RAW_BITS (RAW_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt_valid),
		.evt_stall (evt_stall),
		.evt       (evt),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_wdata   (q_wdata)
	);

	ted_queue #(
		.W     (QW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.nempty (q_nempty)
	);

	ted_back #(
		.RAW_BITS (RAW_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_nempty  (q_nempty),
		.q_rdata   (q_rdata),
		.q_pop     (q_pop),
		.x_min     (x_min_q),
		.x_max     (x_max_q),
		.y_min     (y_min_q),
		.y_max     (y_max_q),
		.view      (view_q),
		.rpt_valid (rpt_valid),
		.rpt_stall (rpt_stall),
		.rpt       (rpt)
	);

endmodule

// ===== sim/touch_event_decoder_unit_tb.sv =====
`timescale 1ns / 100ps

module touch_event_decoder_unit_tb;
	import ted_pkg::*;

	localparam int SETTLE_CYCLES = 100;
	localparam int QUIET_LIMIT   = 20000;
	localparam int PHASE_EVENTS  = 175;
	localparam int MAX_SHOWN     = 10;
	localparam int RAW_MIN       = 32'h8000_0000;
	localparam int RAW_MAX       = 32'h7fff_ffff;

	typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	logic              clk;
	logic              arst_n = 1'b0;
	logic              evt_valid = 1'b0;
	logic              evt_stall;
	evt_word_t         evt = '0;
	logic              rpt_valid;
	logic              rpt_stall = 1'b0;
	touch_word_t       rpt;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [CFG_AW-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;

	touch_event_decoder_unit dut (.*);

	// predictor copy of the view registers
	int               view_x_lo = 0;
	int               view_x_hi = 0;
	int               view_y_lo = 0;
	int               view_y_hi = 0;
	logic [DIM_W-1:0] view_w = 13'd1024;
	logic [DIM_W-1:0] view_h = 13'd1024;
	logic [2:0]       view_orient = 3'd0;

	// predictor copy of the contact state
	bit               slot0_sel = 1'b1;
	bit               contact_on = 1'b0;
	bit               btn_pressed = 1'b0;
	bit               prev_pressed = 1'b0;
	int               contact_x = 0;
	int               contact_y = 0;
	int               single_x = 0;
	int               single_y = 0;
	logic [PT_W-1:0]  last_x = '0;
	logic [PT_W-1:0]  last_y = '0;

	touch_word_t      expected_reports[$];
	touch_word_t      next_report;
	int               report_errors = 0;
	int               events_sent = 0;
	int               gap_pct = 0;
	int               stall_pct = 0;
	int               quiet_cycles = 0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic longint dim_top(input logic [DIM_W-1:0] d);
		if (d == 0) return 0;
		if (d > SCREEN_DIM_MAX) return SCREEN_DIM_MAX - 1;
		return longint'(d) - 1;
	endfunction

	function automatic longint scale_coord(input longint v, input longint lo, input longint hi,
			input longint out_max);
		longint span;
		longint r;
		span = hi - lo;
		if (span <= 0 || out_max <= 0) return 0;
		r = ((v - lo) * out_max + span / 2) / span;
		if (r < 0) r = 0;
		if (r > out_max) r = out_max;
		return r;
	endfunction

	// updates the tracked state for one event word, returns 1 when a report is due
	function automatic bit decode_event(input evt_word_t e, output touch_word_t rep);
		bit              pressed;
		bit              emit;
		longint          rx;
		longint          ry;
		longint          w1;
		longint          h1;
		longint          sx;
		longint          sy;
		logic [PT_W-1:0] px;
		logic [PT_W-1:0] py;
		pressed = 1'b0;
		emit = 1'b0;
		rx = 0;
		ry = 0;
		sx = 0;
		sy = 0;
		px = '0;
		py = '0;
		rep = '0;
		if (e.req_type == EV_ABS) begin
			case (e.event_code)
				CODE_MT_SLOT: slot0_sel = (e.event_value == 0);
				CODE_MT_TRACK_ID: if (slot0_sel) contact_on = !e.event_value[31];
				CODE_MT_POS_X: if (slot0_sel) contact_x = e.event_value;
				CODE_MT_POS_Y: if (slot0_sel) contact_y = e.event_value;
				ABS_X: single_x = e.event_value;
				ABS_Y: single_y = e.event_value;
				default: ;
			endcase
			return 1'b0;
		end
		if (e.req_type == EV_KEY) begin
			if (e.event_code == CODE_TOUCH_BTN) btn_pressed = (e.event_value != 0);
			return 1'b0;
		end
		if (e.req_type != EV_SYN || e.event_code != CODE_SYNC_FRAME) return 1'b0;

		// multitouch contact wins over the single-touch point
		if (contact_on) begin
			rx = contact_x;
			ry = contact_y;
			pressed = 1'b1;
		end else if (btn_pressed) begin
			rx = single_x;
			ry = single_y;
			pressed = 1'b1;
		end
		if (pressed) begin
			w1 = dim_top(view_w);
			h1 = dim_top(view_h);
			if (view_orient[0]) begin
				sx = scale_coord(ry, view_y_lo, view_y_hi, w1);
				sy = scale_coord(rx, view_x_lo, view_x_hi, h1);
			end else begin
				sx = scale_coord(rx, view_x_lo, view_x_hi, w1);
				sy = scale_coord(ry, view_y_lo, view_y_hi, h1);
			end
			if (view_orient[1]) sx = w1 - sx;
			if (view_orient[2]) sy = h1 - sy;
			px = sx[PT_W-1:0];
			py = sy[PT_W-1:0];
		end
		if (pressed && !prev_pressed) begin
			emit = 1'b1;
			rep.touch_kind = KIND_DOWN;
		end else if (pressed && (px != last_x || py != last_y)) begin
			emit = 1'b1;
			rep.touch_kind = KIND_MOVE;
		end else if (!pressed && prev_pressed) begin
			emit = 1'b1;
			rep.touch_kind = KIND_UP;
		end
		rep.screen_x = pressed ? px : last_x;
		rep.screen_y = pressed ? py : last_y;
		if (pressed) begin
			last_x = px;
			last_y = py;
		end
		prev_pressed = pressed;
		return emit;
	endfunction

	task automatic flag_report(input string msg);
		report_errors++;
		if (report_errors <= MAX_SHOWN) $display("%0t: %s", $time, msg);
	endtask

	// report side: random stall and compare against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && rpt_valid === 1'b1 && rpt_stall === 1'b0) begin
			if (expected_reports.size() == 0) begin
				flag_report($sformatf("unexpected report: kind %0d x %0d y %0d",
					rpt.touch_kind, rpt.screen_x, rpt.screen_y));
			end else begin
				next_report = expected_reports.pop_front();
				if (rpt.touch_kind !== next_report.touch_kind ||
						rpt.screen_x !== next_report.screen_x ||
						rpt.screen_y !== next_report.screen_y) begin
					flag_report($sformatf(
						"report mismatch: expected kind %0d x %0d y %0d, got kind %0d x %0d y %0d",
						next_report.touch_kind, next_report.screen_x, next_report.screen_y,
						rpt.touch_kind, rpt.screen_x, rpt.screen_y));
				end
			end
		end
		rpt_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if ((evt_valid && !evt_stall) || (rpt_valid && !rpt_stall) || psel) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic send_event(input logic [4:0] ev_type, input logic [9:0] ev_code,
			input int ev_value, input bit counted);
		evt_word_t   w;
		touch_word_t rep;
		w.req_type = ev_type;
		w.event_code = ev_code;
		w.event_value = ev_value;
		while ($urandom_range(99) < gap_pct) begin
			evt_valid <= 1'b0;
			@(posedge clk);
		end
		evt <= w;
		evt_valid <= 1'b1;
		do @(posedge clk); while (evt_stall !== 1'b0);
		if (decode_event(w, rep)) expected_reports.push_back(rep);
		if (counted) events_sent++;
	endtask

	task automatic wait_drained();
		evt_valid <= 1'b0;
		do @(posedge clk); while (expected_reports.size() != 0);
	endtask

	task automatic apb_cycle(input logic [2:0] idx, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		case (idx)
			REG_X_MIN: view_x_lo = data;
			REG_X_MAX: view_x_hi = data;
			REG_Y_MIN: view_y_lo = data;
			REG_Y_MAX: view_y_hi = data;
			REG_WIDTH: view_w = data[DIM_W-1:0];
			REG_HEIGHT: view_h = data[DIM_W-1:0];
			REG_ORIENT: view_orient = data[2:0];
			default: ;
		endcase
	endtask

	// waits until the mapper has gone quiet before writing
	task automatic write_config(input int x_lo, x_hi, y_lo, y_hi,
			input logic [DIM_W-1:0] w, h, input logic [2:0] orient);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		apb_cycle(REG_X_MIN, x_lo);
		apb_cycle(REG_X_MAX, x_hi);
		apb_cycle(REG_Y_MIN, y_lo);
		apb_cycle(REG_Y_MAX, y_hi);
		apb_cycle(REG_WIDTH, 32'(w));
		apb_cycle(REG_HEIGHT, 32'(h));
		apb_cycle(REG_ORIENT, 32'(orient));
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_idle(input idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				gap_pct = 0;
				stall_pct = 0;
			end
			IDLE_SENDER: begin
				gap_pct = 73;
				stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				gap_pct = 0;
				stall_pct = 73;
			end
			default: begin
				gap_pct = 30;
				stall_pct = 30;
			end
		endcase
	endtask

	// mostly inside the device range, with the edges and wild values mixed in
	function automatic int pick_coord(input int lo, input int hi);
		int     sel;
		longint span;
		sel = $urandom_range(99);
		if (sel < 8) return lo;
		if (sel < 16) return hi;
		if (sel < 28 || hi <= lo) return $urandom;
		span = longint'(hi) - longint'(lo);
		return int'(longint'(lo) + longint'($urandom) % (span + 1));
	endfunction

	task automatic send_random_frame();
		int sel;
		sel = $urandom_range(99);
		if (sel < 45) begin
			sel = $urandom_range(9);
			if (sel == 0) begin
				send_event(EV_ABS, CODE_MT_SLOT,
					($urandom_range(3) == 0) ? $urandom : $urandom_range(1, 9), 1'b1);
			end else if (sel < 5) begin
				send_event(EV_ABS, CODE_MT_SLOT, 0, 1'b1);
			end
			sel = $urandom_range(19);
			if (sel < 3) begin
				send_event(EV_ABS, CODE_MT_TRACK_ID,
					(sel == 0) ? -1 : ($urandom | 32'h8000_0000), 1'b1);
			end else if (sel < 15) begin
				send_event(EV_ABS, CODE_MT_TRACK_ID,
					(sel == 3) ? ($urandom & RAW_MAX) : $urandom_range(0, 65535), 1'b1);
			end
			if ($urandom_range(4) != 0)
				send_event(EV_ABS, CODE_MT_POS_X, pick_coord(view_x_lo, view_x_hi), 1'b1);
			if ($urandom_range(4) != 0)
				send_event(EV_ABS, CODE_MT_POS_Y, pick_coord(view_y_lo, view_y_hi), 1'b1);
			send_event(EV_SYN, CODE_SYNC_FRAME, ($urandom_range(3) == 0) ? $urandom : 0, 1'b1);
		end else if (sel < 75) begin
			if ($urandom_range(4) != 0)
				send_event(EV_ABS, ABS_X, pick_coord(view_x_lo, view_x_hi), 1'b1);
			if ($urandom_range(4) != 0)
				send_event(EV_ABS, ABS_Y, pick_coord(view_y_lo, view_y_hi), 1'b1);
			sel = $urandom_range(9);
			if (sel < 2) send_event(EV_KEY, CODE_TOUCH_BTN, 0, 1'b1);
			else if (sel < 4) send_event(EV_KEY, CODE_TOUCH_BTN, 1, 1'b1);
			else if (sel == 4) send_event(EV_KEY, CODE_TOUCH_BTN, $urandom, 1'b1);
			send_event(EV_SYN, CODE_SYNC_FRAME, ($urandom_range(3) == 0) ? $urandom : 0, 1'b1);
		end else if (sel < 85) begin
			// repeated sync, mostly reports nothing new
			send_event(EV_SYN, CODE_SYNC_FRAME, 0, 1'b1);
		end else if (sel < 93) begin
			send_event(5'($urandom), 10'($urandom), $urandom, 1'b1);
		end else begin
			sel = $urandom_range(2);
			send_event((sel == 0) ? EV_SYN : ((sel == 1) ? EV_KEY : EV_ABS),
				10'($urandom), $urandom, 1'b1);
		end
	endtask

	// power-on view: empty spans so every point lands at the origin
	task automatic test_reset_view();
		send_event(EV_KEY, CODE_TOUCH_BTN, 1, 1'b0);
		send_event(EV_SYN, CODE_SYNC_FRAME, 0, 1'b0);
		send_event(EV_SYN, CODE_SYNC_FRAME, 0, 1'b0);
		send_event(EV_KEY, CODE_TOUCH_BTN, 0, 1'b0);
		send_event(EV_SYN, CODE_SYNC_FRAME, 0, 1'b0);
		send_event(EV_SYN, CODE_SYNC_FRAME, 0, 1'b0);
	endtask

	task automatic test_contact_tracking();
		write_config(RAW_MIN, RAW_MAX, 0, 4095, 13'd4096, 13'd8191, 3'd0);
		send_event(EV_ABS, CODE_MT_SLOT, 0, 1'b0);
		send_event(EV_ABS, CODE_MT_TRACK_ID, RAW_MAX, 1'b0);
		send_event(EV_ABS, CODE_MT_POS_X, RAW_MIN, 1'b0);
		send_event(EV_ABS, CODE_MT_POS_Y, 4095, 1'b0);
		send_event(EV_SYN, CODE_SYNC_FRAME, 0, 1'b0);
		// other slot selected: position and release must not stick
		send_event(EV_ABS, CODE_MT_SLOT, 1, 1'b0);
		send_event(EV_ABS, CODE_MT_POS_X, RAW_MAX, 1'b0);
		send_event(EV_ABS, CODE_MT_TRACK_ID, -1, 1'b0);
		send_event(EV_SYN, CODE_SYNC_FRAME, 0, 1'b0);
		send_event(EV_ABS, CODE_MT_SLOT, 0, 1'b0);
		send_event(EV_ABS, CODE_MT_POS_X, RAW_MAX, 1'b0);
		send_event(EV_SYN, CODE_SYNC_FRAME, 0, 1'b0);
		send_event(EV_ABS, CODE_MT_TRACK_ID, RAW_MIN, 1'b0);
		send_event(EV_SYN, CODE_SYNC_FRAME, 0, 1'b0);
	endtask

	task automatic test_ignored_events();
		send_event(5'd31, 10'd1023, $urandom, 1'b0);
		send_event(5'd2, CODE_TOUCH_BTN, 1, 1'b0);
		send_event(EV_SYN, 10'd1023, 0, 1'b0);
		send_event(EV_KEY, 10'd1023, 1, 1'b0);
		send_event(EV_ABS, 10'd1023, RAW_MAX, 1'b0);
		send_event(EV_KEY, CODE_TOUCH_BTN, RAW_MIN, 1'b0);
		send_event(EV_ABS, ABS_X, RAW_MAX, 1'b0);
		send_event(EV_ABS, ABS_Y, RAW_MIN, 1'b0);
		send_event(EV_SYN, CODE_SYNC_FRAME, RAW_MAX, 1'b0);
		send_event(EV_KEY, CODE_TOUCH_BTN, 0, 1'b0);
		send_event(EV_SYN, CODE_SYNC_FRAME, 0, 1'b0);
	endtask

	task automatic test_random_phases();
		int target;
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: write_config(0, 4095, 0, 4095, 13'd1024, 13'd768, 3'(phase));
				1: write_config(-1000, 3000, 200, 1800, 13'd800, 13'd480, 3'(phase));
				2: write_config(RAW_MIN, RAW_MAX, RAW_MIN, RAW_MAX, 13'd4096, 13'd4096, 3'(phase));
				3: write_config(500, 500, 1000, -1000, 13'd0, 13'd8191, 3'(phase));
				4: write_config(0, 10, 0, 10, 13'd1, 13'd2, 3'(phase));
				5: write_config($urandom, $urandom, $urandom, $urandom,
					13'($urandom), 13'($urandom), 3'(phase));
				6: write_config(0, 3, -3, 0, 13'd4096, 13'd4095, 3'(phase));
				default: write_config(100, 9000, 50, 6000, 13'd4097, 13'd2048, 3'(phase));
			endcase
			set_idle(idle_mode_t'(phase % 4));
			target = events_sent + PHASE_EVENTS;
			while (events_sent < target) begin
				send_random_frame();
				// now and then hold the sender until the report queue is empty
				if ($urandom_range(49) == 0) wait_drained();
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_view();
		test_contact_tracking();
		test_ignored_events();
		test_random_phases();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_reports.size() != 0) begin
			$display("%0d reports never came", expected_reports.size());
			report_errors += expected_reports.size();
		end
		if (report_errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
